>>> design/ssmd_pkg.sv
// Shared types, constants and the segment font for the seven-segment scan driver.
package ssmd_pkg;

    // Digit count and the widths that follow from it
    localparam int unsigned NUM_DIGITS = 3;
    localparam int unsigned POS_W      = 2;
    localparam int unsigned SEG_W      = 8;
    localparam int unsigned BIT_IDX_W  = 3;
    localparam int unsigned VALUE_W    = 16;
    localparam int unsigned SAT_W      = 10;

    // Largest number three digits can show
    localparam logic [SAT_W-1:0] MAX_VALUE = 10'd999;

    // Reciprocal constants: x*41>>12 is x/100 and x*205>>11 is x/10 for x <= 999
    localparam logic [5:0] RECIP_100 = 6'd41;
    localparam logic [7:0] RECIP_10  = 8'd205;

    // Reset look: digit 1 carries the point, giving "00.0"
    localparam logic [POS_W-1:0] POINT_RESET = 2'd1;

    // Highest and lowest bit positions of a segment byte
    localparam logic [BIT_IDX_W-1:0] BIT_FIRST = 3'd7;
    localparam logic [BIT_IDX_W-1:0] BIT_LAST  = 3'd0;

    // Request kinds
    typedef enum logic {
        OP_TICK = 1'b0,
        OP_LOAD = 1'b1
    } t_opcode;

    // Segment byte for one decimal digit: bit7..bit1 = a..g, bit0 = point
    function automatic logic [SEG_W-1:0] seg_font(input logic [3:0] digit);
        logic [SEG_W-1:0] seg;
        unique case (digit)
            4'd0:    seg = 8'b1111_1100;
            4'd1:    seg = 8'b0110_0000;
            4'd2:    seg = 8'b1101_1010;
            4'd3:    seg = 8'b1111_0010;
            4'd4:    seg = 8'b0110_0110;
            4'd5:    seg = 8'b1011_0110;
            4'd6:    seg = 8'b1011_1110;
            4'd7:    seg = 8'b1110_0000;
            4'd8:    seg = 8'b1111_1110;
            4'd9:    seg = 8'b1111_0110;
            default: seg = 8'b0000_0000;
        endcase
        return seg;
    endfunction

endpackage

>>> design/seven_segment_mux_display.sv
// Top level: three-digit multiplexed seven-segment driver with serial segment output.
//
// A load request (tuser = 1) saturates tdata at 999, splits it into hundreds, tens and
// ones and stores one segment byte per digit, the decimal point set on the digit chosen
// by the point register; it is absorbed in the input stage and gives no
// output. A tick request (tuser = 0) shifts the byte of the current scan digit out MSB
// first as eight output beats, one per cycle when the sink is ready; the eighth beat
// carries tlast and the one-hot digit select. The scan pointer moves on to the next
// digit when the tick starts. The output shift register sets the rate: a tick holds it
// until its last beat is taken, and the next tick waits in the input register until
// then, while a load does not wait for it. A point change applies from the next load on.
module seven_segment_mux_display (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: point digit
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_wr_data,
    // input requests
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] display_value
    input  logic        s_axis_tuser,   // [0] opcode
    // output beats
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [0] serial_bit, [3:1] bit_index,
                                        // [6:4] digit_enable, [7] zero
    output logic        m_axis_tlast    // latch_last
);

    // Configuration
    logic [ssmd_pkg::POS_W-1:0]   r_point;

    // Input register
    logic                          r_in_valid;
    ssmd_pkg::t_opcode             r_in_op;
    logic [ssmd_pkg::VALUE_W-1:0]  r_in_value;

    // Segment store and scan pointer
    logic [ssmd_pkg::SEG_W-1:0]    r_store [ssmd_pkg::NUM_DIGITS];
    logic [ssmd_pkg::POS_W-1:0]    r_scan;

    // Output shift register
    logic                          r_out_valid;
    logic [ssmd_pkg::SEG_W-1:0]    r_byte;
    logic [ssmd_pkg::BIT_IDX_W-1:0] r_bit_idx;
    logic [ssmd_pkg::POS_W-1:0]    r_pos;

    // Next values
    logic                          n_in_valid;
    logic                          n_out_valid;
    logic [ssmd_pkg::SEG_W-1:0]    n_byte;
    logic [ssmd_pkg::BIT_IDX_W-1:0] n_bit_idx;
    logic [ssmd_pkg::POS_W-1:0]    n_pos;
    logic [ssmd_pkg::POS_W-1:0]    n_scan;

    // Handshake helpers
    logic in_acc;
    logic out_acc;
    logic out_last;
    logic shift_free;
    logic in_done;
    logic do_load;
    logic do_tick;

    // Digit split
    logic [ssmd_pkg::SAT_W-1:0] sat_value;
    logic [15:0]                prod_100;
    logic [17:0]                prod_10;
    logic [3:0]                 dig_hund;
    logic [6:0]                 quot_10;
    logic [6:0]                 hund_x10;
    logic [ssmd_pkg::SAT_W-1:0] quot_x10;
    logic [6:0]                 tens_full;
    logic [ssmd_pkg::SAT_W-1:0] ones_full;
    logic [3:0]                 dig [ssmd_pkg::NUM_DIGITS];

    // Handshakes
    assign out_last   = (r_bit_idx == ssmd_pkg::BIT_LAST);
    assign out_acc    = r_out_valid && m_axis_tready;
    assign shift_free = !r_out_valid || (m_axis_tready && out_last);
    assign do_load    = r_in_valid && (r_in_op == ssmd_pkg::OP_LOAD);
    assign do_tick    = r_in_valid && (r_in_op == ssmd_pkg::OP_TICK) && shift_free;
    assign in_done    = do_load || do_tick;
    assign s_axis_tready = !r_in_valid || in_done;
    assign in_acc     = s_axis_tvalid && s_axis_tready;

    // Saturate and split into decimal digits by reciprocal multiplication
    always_comb begin
        sat_value = (r_in_value > 16'(ssmd_pkg::MAX_VALUE)) ? ssmd_pkg::MAX_VALUE
                                                            : r_in_value[ssmd_pkg::SAT_W-1:0];
        prod_100  = 16'(sat_value) * 16'(ssmd_pkg::RECIP_100);
        prod_10   = 18'(sat_value) * 18'(ssmd_pkg::RECIP_10);
        dig_hund  = prod_100[15:12];
        quot_10   = prod_10[17:11];
        hund_x10  = 7'(dig_hund) * 7'd10;
        quot_x10  = 10'(quot_10) * 10'd10;
        tens_full = quot_10 - hund_x10;
        ones_full = sat_value - quot_x10;
        dig[0]    = dig_hund;
        dig[1]    = tens_full[3:0];
        dig[2]    = ones_full[3:0];
    end

    // Shift register and scan pointer control
    always_comb begin
        n_in_valid  = in_acc || (r_in_valid && !in_done);
        n_out_valid = r_out_valid;
        n_byte      = r_byte;
        n_bit_idx   = r_bit_idx;
        n_pos       = r_pos;
        n_scan      = r_scan;
        priority if (do_tick) begin
            // start a new byte at the current scan digit
            n_out_valid = 1'b1;
            n_byte      = r_store[r_scan];
            n_bit_idx   = ssmd_pkg::BIT_FIRST;
            n_pos       = r_scan;
            n_scan      = (r_scan == ssmd_pkg::POS_W'(ssmd_pkg::NUM_DIGITS - 1))
                          ? '0 : r_scan + 1'b1;
        end else if (out_acc) begin
            // advance to the next bit, or drop after the last
            if (out_last) begin
                n_out_valid = 1'b0;
            end else begin
                n_bit_idx = r_bit_idx - 1'b1;
            end
        end else begin
            // hold the current beat
            n_bit_idx = r_bit_idx;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point     <= ssmd_pkg::POINT_RESET;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_scan      <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_point <= i_cfg_wr_data;
            end
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            r_scan      <= n_scan;
        end
    end

    // Segment store: reset shows "00.0", load rewrites all digits
    always_ff @(posedge i_clk) begin
        for (int d = 0; d < ssmd_pkg::NUM_DIGITS; d++) begin
            if (!i_rst_n) begin
                r_store[d] <= ssmd_pkg::seg_font(4'd0) |
                              {7'd0, (ssmd_pkg::POS_W'(d) == ssmd_pkg::POINT_RESET)};
            end else if (do_load) begin
                r_store[d] <= ssmd_pkg::seg_font(dig[d]) |
                              {7'd0, (ssmd_pkg::POS_W'(d) == r_point)};
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_op    <= ssmd_pkg::t_opcode'(s_axis_tuser);
            r_in_value <= s_axis_tdata;
        end
        r_byte    <= n_byte;
        r_bit_idx <= n_bit_idx;
        r_pos     <= n_pos;
    end

    // Output beat
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = out_last;
    assign m_axis_tdata  = {1'b0,
                            (out_last ? (3'd1 << r_pos) : 3'd0),
                            r_bit_idx,
                            r_byte[r_bit_idx]};

`ifndef NO_ASSERTIONS
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan < ssmd_pkg::POS_W'(ssmd_pkg::NUM_DIGITS))
        else $error("scan pointer out of range");

    a_select_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> $onehot(m_axis_tdata[6:4]))
        else $error("last beat without one-hot digit select");

    a_select_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[6:4] == 3'd0))
        else $error("digit select on while shifting");

    a_bit_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && m_axis_tready && !out_last) |=>
            (r_out_valid && (r_bit_idx == $past(r_bit_idx) - 3'd1)))
        else $error("bit index did not step down");

    a_tick_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && (r_in_op == ssmd_pkg::OP_TICK) && r_out_valid && !out_last)
            |-> !s_axis_tready)
        else $error("tick taken while a byte is mid-shift");
`endif

endmodule
